// ----- rtl/cp437_to_utf8_encoder_macros.svh -----
`ifndef CP437_TO_UTF8_ENCODER_MACROS_SVH
`define CP437_TO_UTF8_ENCODER_MACROS_SVH

// clocked check, masked while reset is low
`define C2U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define C2U_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/c2u_pkg.sv -----
package c2u_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 16;
  localparam int unsigned MaxBytes = 3;

  localparam logic [CpW-1:0] TwoByteMax = 16'h07FF;

  localparam logic [2:0] LeadTwo   = 3'b110;
  localparam logic [3:0] LeadThree = 4'b1110;
  localparam logic [1:0] ContTag   = 2'b10;

  localparam logic [CpW-1:0] UpperMap [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  typedef struct packed {
    logic           ascii;
    logic [CpW-1:0] cp;
  } cp_item_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
  } char_item_t;

endpackage

// ----- rtl/c2u_lookup.sv -----
module c2u_lookup import c2u_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cp_item_t         out_item_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s2_valid_q, s2_valid_d;
  cp_item_t         s2_item_q, s2_item_d;
  logic             s1_ready, s2_ready;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  always_comb begin
    s2_item_d.ascii = !s1_byte_q[ByteW-1];
    if (s1_byte_q[ByteW-1]) begin
      s2_item_d.cp = UpperMap[s1_byte_q[ByteW-2:0]];
    end else begin
      s2_item_d.cp = {{(CpW-ByteW){1'b0}}, s1_byte_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_byte_q <= in_byte_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_item_q <= s2_item_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = s2_item_q;

endmodule

// ----- rtl/c2u_encode.sv -----
module c2u_encode import c2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cp_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output char_item_t out_item_o
);

  logic       valid_q, valid_d;
  char_item_t item_q, item_d;
  logic       ready;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;
  assign valid_d    = ready ? in_valid_i : valid_q;

  always_comb begin
    item_d.bytes = '0;
    if (in_item_i.ascii) begin
      item_d.cnt      = 2'd1;
      item_d.bytes[0] = in_item_i.cp[ByteW-1:0];
    end else if (in_item_i.cp <= TwoByteMax) begin
      item_d.cnt      = 2'd2;
      item_d.bytes[0] = {LeadTwo, in_item_i.cp[10:6]};
      item_d.bytes[1] = {ContTag, in_item_i.cp[5:0]};
    end else begin
      item_d.cnt      = 2'd3;
      item_d.bytes[0] = {LeadThree, in_item_i.cp[15:12]};
      item_d.bytes[1] = {ContTag, in_item_i.cp[11:6]};
      item_d.bytes[2] = {ContTag, in_item_i.cp[5:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- rtl/c2u_serial.sv -----
module c2u_serial import c2u_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  char_item_t       in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  logic       valid_q, valid_d;
  char_item_t item_q;
  logic [1:0] idx_q, idx_d;
  logic       fire, last, load;

  assign last       = (idx_q == (item_q.cnt - 2'd1));
  assign fire       = valid_q && out_ready_i;
  assign in_ready_o = !valid_q || (out_ready_i && last);
  assign load       = in_ready_o && in_valid_i;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (fire) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = item_q.bytes[idx_q];
  assign out_last_o  = valid_q && last;

`include "cp437_to_utf8_encoder_macros.svh"

  `C2U_ASSERT(a_idx_in_range, valid_q |-> (idx_q < item_q.cnt), "byte index beyond char length")
  `C2U_ASSERT(a_lead_tag, (valid_q && idx_q == 2'd0 && item_q.cnt != 2'd1) |-> (out_byte_o[7:6] == 2'b11), "multi-byte char without lead tag")
  `C2U_ASSERT(a_cont_tag, (valid_q && idx_q != 2'd0) |-> (out_byte_o[7:6] == ContTag), "continuation byte without 10 tag")
  `C2U_ASSERT(a_drain, (fire && last && !in_valid_i) |=> !valid_q, "serializer held a finished char")
  `C2U_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !valid_q || $past(rst_ni), "serializer valid out of reset")

endmodule

// ----- rtl/cp437_to_utf8_encoder.sv -----
// the first utf-8 byte of a char passes the lookup s1 and s2, encode and serializer registers
// before it is offered; an ascii char gives one byte, an upper char two or three bytes;
// the single 8-bit output lane sets the rate, and the input waits when later stages stall
// reset: asynchronous active-low, clears all valid bits, no output beat until new input

module cp437_to_utf8_encoder import c2u_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast
);

  logic       cp_valid, cp_ready;
  cp_item_t   cp_item;
  logic       ch_valid, ch_ready;
  char_item_t ch_item;

  c2u_lookup u_lookup (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (cp_valid),
    .out_ready_i (cp_ready),
    .out_item_o  (cp_item)
  );

  c2u_encode u_encode (
    .clk_i,
    .rst_ni,
    .in_valid_i  (cp_valid),
    .in_ready_o  (cp_ready),
    .in_item_i   (cp_item),
    .out_valid_o (ch_valid),
    .out_ready_i (ch_ready),
    .out_item_o  (ch_item)
  );

  c2u_serial u_serial (
    .clk_i,
    .rst_ni,
    .in_valid_i  (ch_valid),
    .in_ready_o  (ch_ready),
    .in_item_i   (ch_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
